### rtl/nfts_pkg.sv
// ============================================================================
// nfts_pkg: shared types and constants of the nearest free tile search
// Field widths, result status codes, register indexes and the command and
// status bundles that join the controller to the datapath.
// ============================================================================
package nfts_pkg;

    localparam int PIX_W     = 11;
    localparam int CFG_W     = 7;
    localparam int COORD_W   = 6;
    localparam int RING_W    = 7;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

    // Item command codes.
    localparam logic CMD_FIND   = 1'b0;
    localparam logic CMD_TOGGLE = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_START_OPEN = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NONE       = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TOGGLED    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_REFUSED    = 3'd5;

    typedef struct packed {
        logic clear;      // clear one map row
        logic capture;    // latch the item
        logic divide;     // pixel to tile conversion
        logic read_tile;  // read the row of the item tile
        logic set_start;  // record the start tile
        logic take_start; // best tile becomes the start tile
        logic toggle_wr;  // write back the row with the tile flipped
        logic ring_init;  // set up ring one around the start tile
        logic step;       // probe one ring cell
        logic take_hit;   // best tile becomes the probed cell
        logic clr_ring;   // report ring zero
    } t_dp_cmd;

    typedef struct packed {
        logic cfg_change; // a grid size write changed the size
        logic clear_done; // last map row is being cleared
        logic is_toggle;  // held item is a toggle
        logic in_grid;    // held item tile lies inside the grid
        logic is_start;   // held item tile equals the start tile
        logic cell_open;  // held item tile is passable
        logic hit;        // probed ring cell is inside and passable
        logic last;       // probed ring cell was the final one
    } t_dp_sts;

endpackage

### rtl/nfts_ctrl.sv
// ============================================================================
// nfts_ctrl: sequencer of the nearest free tile search
// Runs the map clearing pass and steps each transaction through conversion,
// tile check and ring walk, and drives the result strobe and status code.
// ============================================================================
module nfts_ctrl
    import nfts_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  t_dp_sts             i_sts,
    output t_dp_cmd             o_cmd,
    output logic                busy,
    output logic                o_done,
    output logic [STATUS_W-1:0] o_status
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_CHECK,
        S_EVAL,
        S_SEARCH
    } t_state;

    t_state              r_state, n_state;
    logic                r_done, n_done;
    logic [STATUS_W-1:0] r_status, n_status;
    logic                r_busy;

    always_comb begin
        o_cmd    = '0;
        n_state  = r_state;
        n_done   = 1'b0;
        n_status = r_status;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (!i_sts.cfg_change && i_sts.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_sts.cfg_change) begin
                    n_state = S_CLEAR;
                end else if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.divide = 1'b1;
                n_state      = S_CHECK;
            end
            S_CHECK: begin
                if (!i_sts.in_grid) begin
                    o_cmd.clr_ring = 1'b1;
                    n_done         = 1'b1;
                    n_status       = ST_OUTSIDE;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.read_tile = 1'b1;
                    o_cmd.set_start = !i_sts.is_toggle;
                    n_state         = S_EVAL;
                end
            end
            S_EVAL: begin
                if (!i_sts.is_toggle) begin
                    if (i_sts.cell_open) begin
                        o_cmd.take_start = 1'b1;
                        o_cmd.clr_ring   = 1'b1;
                        n_done           = 1'b1;
                        n_status         = ST_START_OPEN;
                        n_state          = S_IDLE;
                    end else begin
                        o_cmd.ring_init = 1'b1;
                        n_state         = S_SEARCH;
                    end
                end else if (i_sts.is_start) begin
                    o_cmd.clr_ring = 1'b1;
                    n_done         = 1'b1;
                    n_status       = ST_REFUSED;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.toggle_wr = 1'b1;
                    o_cmd.clr_ring  = 1'b1;
                    n_done          = 1'b1;
                    n_status        = ST_TOGGLED;
                    n_state         = S_IDLE;
                end
            end
            S_SEARCH: begin
                o_cmd.step = 1'b1;
                if (i_sts.hit) begin
                    o_cmd.take_hit = 1'b1;
                    n_done         = 1'b1;
                    n_status       = ST_FOUND;
                    n_state        = S_IDLE;
                end else if (i_sts.last) begin
                    o_cmd.clr_ring = 1'b1;
                    n_done         = 1'b1;
                    n_status       = ST_NONE;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_done   <= 1'b0;
            r_status <= ST_START_OPEN;
            r_busy   <= 1'b1;
        end else begin
            r_state  <= n_state;
            r_done   <= n_done;
            r_status <= n_status;
            r_busy   <= (n_state != S_IDLE);
        end
    end

    assign busy     = r_busy;
    assign o_done   = r_done;
    assign o_status = r_status;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("result strobe while the block is still busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !r_busy) |=> r_busy)
        else $error("accepted transaction did not make the block busy");

    a_done_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("result strobe without preceding work");

    a_hit_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH && i_sts.hit) |=> (r_done && r_status == ST_FOUND))
        else $error("ring hit not reported as found");

endmodule

### rtl/nfts_datapath.sv
// ============================================================================
// nfts_datapath: map memory, grid registers and ring walker
// Holds the passable map as one row per word, converts pixels to tiles and
// walks the search rings one cell per cycle.
// ============================================================================
module nfts_datapath
    import nfts_pkg::*;
#(
    parameter int MAX_DIM   = 64,
    parameter int TILE_SIZE = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic                 i_item_cmd,
    input  logic [PIX_W-1:0]     i_pixel_x,
    input  logic [PIX_W-1:0]     i_pixel_y,
    output logic [COORD_W-1:0]   o_best_x,
    output logic [COORD_W-1:0]   o_best_y,
    output logic [RING_W-1:0]    o_ring
);

    localparam int CW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int GW = $clog2(MAX_DIM + 1);
    localparam int PW = CW + 2;
    localparam int VW = (CFG_W > GW) ? CFG_W : GW;
    localparam int QW = (PIX_W > GW) ? PIX_W : GW;
    localparam int RESET_DIM = (MAX_DIM < 10) ? MAX_DIM : 10;
    // Exact floor division of an unsigned PIX_W-bit value by TILE_SIZE
    // through a rounded-up reciprocal.
    localparam int SHIFT  = PIX_W + $clog2(TILE_SIZE);
    localparam int MULT   = ((2 ** SHIFT) + TILE_SIZE - 1) / TILE_SIZE;
    localparam int MULT_W = PIX_W + 2;
    localparam int PROD_W = PIX_W + MULT_W;

    typedef enum logic [1:0] {
        SEG_TOP,
        SEG_RIGHT,
        SEG_BOTTOM,
        SEG_LEFT
    } t_seg;

    // Map storage and its read register.
    logic [MAX_DIM-1:0] r_map [MAX_DIM];
    logic [MAX_DIM-1:0] r_row;

    // Grid size and clearing sweep.
    logic [GW-1:0] r_gw, r_gh;
    logic [CW-1:0] r_clr_row;

    // Held item.
    logic             r_cmd;
    logic [PIX_W-1:0] r_px, r_py;
    logic [PIX_W-1:0] r_tx, r_ty;

    // Start and best tiles, reported ring.
    logic [CW-1:0]     r_start_x, r_start_y;
    logic [CW-1:0]     r_best_x, r_best_y;
    logic [RING_W-1:0] r_ring;

    // Ring walker.
    logic [PW-1:0] r_gx, r_gy, n_gx, n_gy;
    logic [PW-1:0] r_xl, r_xr, r_yt, r_yb;
    logic [PW-1:0] n_xl, n_xr, n_yt, n_yb;
    t_seg          r_seg, n_seg;
    logic [GW-1:0] r_d, n_d;

    // Probe stage.
    logic          r_p_act, r_p_valid, r_p_last;
    logic [CW-1:0] r_p_x, r_p_y;
    logic [GW-1:0] r_p_d;

    logic [GW-1:0]     largest;
    logic              gen_in_grid, ring_end, last_cell;
    logic [VW-1:0]     cfg_ext, cfg_sat;
    logic [GW-1:0]     cfg_dim;
    logic              cfg_ok, wr_w, wr_h;
    logic [PROD_W-1:0] prod_x, prod_y;
    logic [QW-1:0]     tx_ext, ty_ext;
    logic [PW-1:0]     sx_ext, sy_ext;

    // ---------------- configuration ----------------
    assign cfg_ext = VW'(i_cfg_wdata);
    assign cfg_sat = (cfg_ext > VW'(MAX_DIM)) ? VW'(MAX_DIM) : cfg_ext;
    assign cfg_dim = GW'(cfg_sat);
    assign cfg_ok  = i_cfg_wr_en && (i_cfg_wdata != '0);
    assign wr_w    = cfg_ok && (i_cfg_idx == REG_GRID_WIDTH) && (cfg_dim != r_gw);
    assign wr_h    = cfg_ok && (i_cfg_idx == REG_GRID_HEIGHT) && (cfg_dim != r_gh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gw <= GW'(RESET_DIM);
            r_gh <= GW'(RESET_DIM);
        end else begin
            if (wr_w) begin
                r_gw <= cfg_dim;
            end
            if (wr_h) begin
                r_gh <= cfg_dim;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_row <= '0;
        end else if (wr_w || wr_h) begin
            r_clr_row <= '0;
        end else if (i_cmd.clear) begin
            if (r_clr_row == CW'(MAX_DIM - 1)) begin
                r_clr_row <= '0;
            end else begin
                r_clr_row <= r_clr_row + CW'(1);
            end
        end
    end

    // ---------------- item capture and conversion ----------------
    assign prod_x = PROD_W'(r_px) * PROD_W'(MULT_W'(MULT));
    assign prod_y = PROD_W'(r_py) * PROD_W'(MULT_W'(MULT));

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd <= i_item_cmd;
            r_px  <= i_pixel_x;
            r_py  <= i_pixel_y;
        end
        if (i_cmd.divide) begin
            r_tx <= PIX_W'(prod_x >> SHIFT);
            r_ty <= PIX_W'(prod_y >> SHIFT);
        end
    end

    assign tx_ext = QW'(r_tx);
    assign ty_ext = QW'(r_ty);

    // ---------------- start, best and ring result ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x <= '0;
            r_start_y <= '0;
            r_best_x  <= '0;
            r_best_y  <= '0;
            r_ring    <= '0;
        end else begin
            if (i_cmd.set_start) begin
                r_start_x <= r_tx[CW-1:0];
                r_start_y <= r_ty[CW-1:0];
            end
            if (i_cmd.take_start) begin
                r_best_x <= r_start_x;
                r_best_y <= r_start_y;
            end else if (i_cmd.take_hit) begin
                r_best_x <= r_p_x;
                r_best_y <= r_p_y;
            end
            if (i_cmd.take_hit) begin
                r_ring <= RING_W'(r_p_d);
            end else if (i_cmd.clr_ring) begin
                r_ring <= '0;
            end
        end
    end

    // ---------------- ring walker ----------------
    assign largest     = (r_gw > r_gh) ? r_gw : r_gh;
    assign sx_ext      = PW'(r_start_x);
    assign sy_ext      = PW'(r_start_y);
    assign gen_in_grid = !r_gx[PW-1] && !r_gy[PW-1]
                         && (r_gx < PW'(r_gw)) && (r_gy < PW'(r_gh));
    assign ring_end    = (r_seg == SEG_LEFT) && (r_gy == r_yt + PW'(1));
    assign last_cell   = ring_end && (r_d == largest);

    always_comb begin
        n_gx  = r_gx;
        n_gy  = r_gy;
        n_xl  = r_xl;
        n_xr  = r_xr;
        n_yt  = r_yt;
        n_yb  = r_yb;
        n_seg = r_seg;
        n_d   = r_d;
        case (r_seg)
            SEG_TOP: begin
                if (r_gx == r_xr) begin
                    n_seg = SEG_RIGHT;
                    n_gy  = r_gy + PW'(1);
                end else begin
                    n_gx = r_gx + PW'(1);
                end
            end
            SEG_RIGHT: begin
                if (r_gy == r_yb) begin
                    n_seg = SEG_BOTTOM;
                    n_gx  = r_gx - PW'(1);
                end else begin
                    n_gy = r_gy + PW'(1);
                end
            end
            SEG_BOTTOM: begin
                if (r_gx == r_xl) begin
                    n_seg = SEG_LEFT;
                    n_gy  = r_gy - PW'(1);
                end else begin
                    n_gx = r_gx - PW'(1);
                end
            end
            SEG_LEFT: begin
                if (ring_end) begin
                    n_seg = SEG_TOP;
                    n_xl  = r_xl - PW'(1);
                    n_xr  = r_xr + PW'(1);
                    n_yt  = r_yt - PW'(1);
                    n_yb  = r_yb + PW'(1);
                    n_gx  = r_xl - PW'(1);
                    n_gy  = r_yt - PW'(1);
                    n_d   = r_d + GW'(1);
                end else begin
                    n_gy = r_gy - PW'(1);
                end
            end
            default: begin
                n_seg = SEG_TOP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ring_init) begin
            r_xl  <= sx_ext - PW'(1);
            r_xr  <= sx_ext + PW'(1);
            r_yt  <= sy_ext - PW'(1);
            r_yb  <= sy_ext + PW'(1);
            r_gx  <= sx_ext - PW'(1);
            r_gy  <= sy_ext - PW'(1);
            r_seg <= SEG_TOP;
            r_d   <= GW'(1);
        end else if (i_cmd.step) begin
            r_xl  <= n_xl;
            r_xr  <= n_xr;
            r_yt  <= n_yt;
            r_yb  <= n_yb;
            r_gx  <= n_gx;
            r_gy  <= n_gy;
            r_seg <= n_seg;
            r_d   <= n_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_act <= 1'b0;
        end else begin
            r_p_act <= i_cmd.step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_p_valid <= gen_in_grid;
            r_p_last  <= last_cell;
            r_p_x     <= r_gx[CW-1:0];
            r_p_y     <= r_gy[CW-1:0];
            r_p_d     <= r_d;
        end
    end

    // ---------------- map memory ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.read_tile) begin
            r_row <= r_map[r_ty[CW-1:0]];
        end else if (i_cmd.step && gen_in_grid) begin
            r_row <= r_map[r_gy[CW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_map[r_clr_row] <= '1;
        end else if (i_cmd.toggle_wr) begin
            r_map[r_ty[CW-1:0]] <= r_row ^ (MAX_DIM'(1) << r_tx[CW-1:0]);
        end
    end

    // ---------------- status ----------------
    always_comb begin
        o_sts            = '0;
        o_sts.cfg_change = wr_w || wr_h;
        o_sts.clear_done = (r_clr_row == CW'(MAX_DIM - 1));
        o_sts.is_toggle  = (r_cmd == CMD_TOGGLE);
        o_sts.in_grid    = (tx_ext < QW'(r_gw)) && (ty_ext < QW'(r_gh));
        o_sts.is_start   = (r_tx[CW-1:0] == r_start_x) && (r_ty[CW-1:0] == r_start_y);
        o_sts.cell_open  = r_row[r_tx[CW-1:0]];
        o_sts.hit        = r_p_act && r_p_valid && r_row[r_p_x];
        o_sts.last       = r_p_act && r_p_last;
    end

    assign o_best_x = COORD_W'(r_best_x);
    assign o_best_y = COORD_W'(r_best_y);
    assign o_ring   = r_ring;

endmodule

### rtl/nearest_free_tile_spiral_search.sv
// ============================================================================
// nearest_free_tile_spiral_search: top level of the nearest free tile search
// Results: an outside-grid transaction is reported after the grid check, a
// toggle or a passable start tile after the tile evaluation, and a blocked
// start tile after a ring walk over rings up to L, the larger grid dimension.
// One transaction at a time; the next one can be accepted in the strobe cycle.
// The ring walk probes one map cell per cycle through the single map read
// port. The receiver cannot stall. Reset and every grid size change made
// while idle or clearing start a clearing pass that writes every map row.
// ============================================================================
module nearest_free_tile_spiral_search
    import nfts_pkg::*;
#(
    parameter int MAX_DIM   = 64,
    parameter int TILE_SIZE = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_cmd,
    input  logic [PIX_W-1:0]     i_pixel_x,
    input  logic [PIX_W-1:0]     i_pixel_y,
    output logic                 o_done,
    output logic [STATUS_W-1:0]  o_status,
    output logic [COORD_W-1:0]   o_closest_x,
    output logic [COORD_W-1:0]   o_closest_y,
    output logic [RING_W-1:0]    o_ring_distance
);

    // The controller sequences each transaction: capture, pixel to tile
    // conversion, grid check with a read of the tile's map row, and then
    // either an immediate result or the ring walk. The datapath holds the
    // map as MAX_DIM words of MAX_DIM bits, one word per tile row, so the
    // clearing pass after reset or a size change writes a whole row per
    // cycle. A toggle is a read-modify-write of one row.
    //
    // During the ring walk, each cycle the walker presents one cell and the
    // row read for it is checked in the following cycle, so the walk keeps
    // a one-cell probe stage in flight. Cells outside the grid are probed
    // as misses. The corners shared between ring sides are visited only
    // once, which leaves the first hit unchanged.
    //
    // The closest tile and ring ports are registers that change only at a
    // result, so they stay valid after the strobe until the next result.

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    nfts_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_sts    (dp_sts),
        .o_cmd    (dp_cmd),
        .busy     (busy),
        .o_done   (o_done),
        .o_status (o_status)
    );

    nfts_datapath #(
        .MAX_DIM   (MAX_DIM),
        .TILE_SIZE (TILE_SIZE)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item_cmd  (i_cmd),
        .i_pixel_x   (i_pixel_x),
        .i_pixel_y   (i_pixel_y),
        .o_best_x    (o_closest_x),
        .o_best_y    (o_closest_y),
        .o_ring      (o_ring_distance)
    );

endmodule

### dv/nearest_free_tile_spiral_search_tb.sv
// ============================================================================
// nearest_free_tile_spiral_search_tb: self-checking bench for the tile search
// Drives find and toggle transactions through the start/busy port, predicts
// every result with a behavioral model of the passable map and the ring walk,
// and checks each strobed result against the oldest prediction. The grid
// size is reprogrammed between phases, down to one tile along a side and up
// to the saturated maximum.
// ============================================================================
module nearest_free_tile_spiral_search_tb;
    import nfts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIM        = 64;
    localparam int TILE_PX    = 32;
    localparam int PIX_MAX    = (1 << PIX_W) - 1;
    localparam int STALL_LIMIT = 100000;

    typedef struct packed {
        logic             cmd;
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] py;
    } t_click;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [RING_W-1:0]   ring;
    } t_answer;

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx   = REG_GRID_WIDTH;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;
    logic                 start       = 1'b0;
    logic                 busy;
    logic                 i_cmd       = CMD_FIND;
    logic [PIX_W-1:0]     i_pixel_x   = '0;
    logic [PIX_W-1:0]     i_pixel_y   = '0;
    logic                 o_done;
    logic [STATUS_W-1:0]  o_status;
    logic [COORD_W-1:0]   o_closest_x;
    logic [COORD_W-1:0]   o_closest_y;
    logic [RING_W-1:0]    o_ring_distance;

    nearest_free_tile_spiral_search #(
        .MAX_DIM   (DIM),
        .TILE_SIZE (TILE_PX)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .start           (start),
        .busy            (busy),
        .i_cmd           (i_cmd),
        .i_pixel_x       (i_pixel_x),
        .i_pixel_y       (i_pixel_y),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_closest_x     (o_closest_x),
        .o_closest_y     (o_closest_y),
        .o_ring_distance (o_ring_distance)
    );

    // 8 ns clock period.
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------------
    // Behavioral copy of the block's state. The map holds one passable bit
    // per tile, indexed row * DIM + column, and every tile starts out open.
    // ------------------------------------------------------------------------
    bit open_map [DIM*DIM];
    int cols     = 10;
    int rows     = 10;
    int anchor_x = 0;   // tile of the last in-grid find
    int anchor_y = 0;
    int near_x   = 0;   // closest passable tile reported so far
    int near_y   = 0;

    t_click  pending_clicks[$];     // transactions still waiting to be driven
    t_answer expected_answers[$];   // predicted results, oldest first
    t_click  on_port;               // transaction currently offered to the block
    bit      steady = 1'b0;         // when set the driver never inserts gaps

    int mismatches   = 0;
    int clicks_sent  = 0;
    int answers_seen = 0;
    int status_seen [6];
    int idle_cycles  = 0;

    initial begin
        foreach (open_map[i]) open_map[i] = 1'b1;
        foreach (status_seen[i]) status_seen[i] = 0;
    end

    function automatic bit tile_open(int x, int y);
        if (x < 0 || y < 0 || x >= cols || y >= rows) return 1'b0;
        return open_map[y*DIM + x];
    endfunction

    // Probes one ring cell and, when it is open, makes it the closest tile.
    function automatic bit claim_tile(int x, int y);
        if (!tile_open(x, y)) return 1'b0;
        near_x = x;
        near_y = y;
        return 1'b1;
    endfunction

    // Walks rings of growing distance around the anchor tile, each one
    // clockwise from its top-left corner, and returns the ring on which an
    // open tile was found, or zero when the walk came up empty.
    function automatic int walk_rings();
        int reach;
        int x;
        int y;
        reach = (cols > rows) ? cols : rows;
        for (int d = 1; d <= reach; d++) begin
            for (x = anchor_x - d; x <= anchor_x + d; x++)
                if (claim_tile(x, anchor_y - d)) return d;
            for (y = anchor_y - d; y <= anchor_y + d; y++)
                if (claim_tile(anchor_x + d, y)) return d;
            for (x = anchor_x + d; x >= anchor_x - d; x--)
                if (claim_tile(x, anchor_y + d)) return d;
            for (y = anchor_y + d; y > anchor_y - d; y--)
                if (claim_tile(anchor_x - d, y)) return d;
        end
        return 0;
    endfunction

    // Applies one accepted transaction to the model state and returns the
    // result the block must produce for it.
    function automatic t_answer predict_answer(t_click c);
        t_answer a;
        int      tx;
        int      ty;
        int      ring;
        tx   = int'(c.px) / TILE_PX;
        ty   = int'(c.py) / TILE_PX;
        ring = 0;
        if (tx >= cols || ty >= rows) begin
            a.status = ST_OUTSIDE;
        end else if (c.cmd == CMD_FIND) begin
            anchor_x = tx;
            anchor_y = ty;
            if (open_map[ty*DIM + tx]) begin
                near_x   = tx;
                near_y   = ty;
                a.status = ST_START_OPEN;
            end else begin
                ring     = walk_rings();
                a.status = (ring != 0) ? ST_FOUND : ST_NONE;
            end
        end else if (tx == anchor_x && ty == anchor_y) begin
            a.status = ST_REFUSED;
        end else begin
            open_map[ty*DIM + tx] = ~open_map[ty*DIM + tx];
            a.status = ST_TOGGLED;
        end
        a.x    = COORD_W'(near_x);
        a.y    = COORD_W'(near_y);
        a.ring = RING_W'(ring);
        return a;
    endfunction

    // Mirrors a grid size write. Zero is ignored, anything above DIM clamps
    // to DIM, and only a real change of size reopens the whole map.
    function automatic void apply_size_write(logic [CFG_IDX_W-1:0] idx, int value);
        int v;
        v = value & 'h7F;
        if (v == 0) return;
        if (v > DIM) v = DIM;
        if (idx == REG_GRID_WIDTH) begin
            if (v == cols) return;
            cols = v;
        end else begin
            if (v == rows) return;
            rows = v;
        end
        foreach (open_map[i]) open_map[i] = 1'b1;
    endfunction

    task automatic flag_error(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // Driver. A transaction is accepted at an edge where start is high and
    // busy is low; the prediction is made right there, so the model sees the
    // transactions in exactly the order the block does. A new transaction is
    // offered only when the port is free, with random gaps unless steady.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                expected_answers.push_back(predict_answer(on_port));
                clicks_sent++;
            end
            if (!start || !busy) begin
                if (pending_clicks.size() != 0 && (steady || $urandom_range(0, 99) >= 26)) begin
                    on_port = pending_clicks.pop_front();
                    start     <= 1'b1;
                    i_cmd     <= on_port.cmd;
                    i_pixel_x <= on_port.px;
                    i_pixel_y <= on_port.py;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Every strobed result is taken at the edge that ends its cycle
    // and compared field by field with the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_done) begin
            answers_seen++;
            if (o_status < 6) status_seen[o_status]++;
            if (expected_answers.size() == 0) begin
                flag_error($sformatf("result with status %0d arrived with none expected",
                                     o_status));
            end else begin
                want = expected_answers.pop_front();
                if (o_status !== want.status)
                    flag_error($sformatf("status got %0d want %0d", o_status, want.status));
                if (o_closest_x !== want.x)
                    flag_error($sformatf("closest_x got %0d want %0d", o_closest_x, want.x));
                if (o_closest_y !== want.y)
                    flag_error($sformatf("closest_y got %0d want %0d", o_closest_y, want.y));
                if (o_ring_distance !== want.ring)
                    flag_error($sformatf("ring_distance got %0d want %0d",
                                         o_ring_distance, want.ring));
            end
        end
    end

    // Watchdog: the run is stuck if neither side moves a transaction for a
    // long time. The limit covers several full 64-ring searches back to back.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("[%0t] no transaction for %0d cycles", $realtime, idle_cycles);
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    task automatic push_click(logic cmd, int px, int py);
        t_click c;
        c.cmd = cmd;
        c.px  = PIX_W'(px);
        c.py  = PIX_W'(py);
        pending_clicks.push_back(c);
    endtask

    // Holds the sender back until every queued transaction is accepted and
    // every result has come back, then lets the block settle. This is also
    // the only point at which the grid size is reprogrammed.
    task automatic quiesce();
        while (pending_clicks.size() != 0 || start || expected_answers.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic write_size(logic [CFG_IDX_W-1:0] idx, int value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= CFG_W'(value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        apply_size_write(idx, value);
    endtask

    // Random transactions clustered around a moving focus tile, so toggles
    // build up blocked patches and finds land on them and start ring walks.
    // A small share are clicks anywhere in the pixel range.
    task automatic random_phase(int count);
        int pick;
        int fx;
        int fy;
        int tx;
        int ty;
        fx = $urandom_range(0, cols - 1);
        fy = $urandom_range(0, rows - 1);
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                fx = $urandom_range(0, cols - 1);
                fy = $urandom_range(0, rows - 1);
            end
            if (pick < 12) begin
                push_click(1'($urandom_range(0, 1)), $urandom_range(0, PIX_MAX),
                           $urandom_range(0, PIX_MAX));
            end else begin
                tx = fx + int'($urandom_range(0, 4)) - 2;
                ty = fy + int'($urandom_range(0, 4)) - 2;
                if (tx < 0 || tx >= cols) tx = $urandom_range(0, cols - 1);
                if (ty < 0 || ty >= rows) ty = $urandom_range(0, rows - 1);
                push_click((pick < 60) ? CMD_TOGGLE : CMD_FIND,
                           tx*TILE_PX + int'($urandom_range(0, TILE_PX - 1)),
                           ty*TILE_PX + int'($urandom_range(0, TILE_PX - 1)));
            end
        end
        quiesce();
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Let the clearing pass after reset finish.
        quiesce();

        // Default 10x10 grid with the anchor at the origin: open start tile,
        // refused toggle of the anchor, clicks past the grid edge, then a
        // blocked start whose first ring is fully closed, so the hit is on
        // ring two.
        push_click(CMD_FIND, 0, 0);
        push_click(CMD_TOGGLE, 31, 31);
        push_click(CMD_FIND, PIX_MAX, PIX_MAX);
        push_click(CMD_TOGGLE, 10*TILE_PX, 0);
        push_click(CMD_TOGGLE, 32, 0);
        push_click(CMD_TOGGLE, 63, 63);
        push_click(CMD_TOGGLE, 0, 32);
        push_click(CMD_FIND, 5*TILE_PX + 17, 5*TILE_PX + 9);
        push_click(CMD_TOGGLE, 0, 0);
        push_click(CMD_FIND, 10, 20);
        push_click(CMD_FIND, 319, 319);
        quiesce();

        // A 2x1 grid: a ring-one hit, then both tiles closed so the walk
        // finds nothing and the closest tile must stay where it was.
        write_size(REG_GRID_WIDTH, 2);
        write_size(REG_GRID_HEIGHT, 1);
        quiesce();
        push_click(CMD_FIND, 32, 0);
        push_click(CMD_TOGGLE, 0, 0);
        push_click(CMD_FIND, 0, 0);
        push_click(CMD_TOGGLE, 32, 0);
        push_click(CMD_FIND, 0, 0);
        push_click(CMD_TOGGLE, 0, 0);
        push_click(CMD_FIND, 64, 0);
        quiesce();

        // A zero write is dropped, oversized values clamp to the full 64x64
        // grid, and rewriting the current size keeps the map untouched.
        write_size(REG_GRID_WIDTH, 0);
        write_size(REG_GRID_WIDTH, 127);
        write_size(REG_GRID_HEIGHT, 127);
        write_size(REG_GRID_HEIGHT, DIM);
        quiesce();
        push_click(CMD_FIND, PIX_MAX, PIX_MAX);
        push_click(CMD_TOGGLE, 1999, PIX_MAX);
        quiesce();
        write_size(REG_GRID_WIDTH, DIM);
        quiesce();
        push_click(CMD_FIND, 1999, PIX_MAX);
        push_click(CMD_TOGGLE, 1999, PIX_MAX);
        quiesce();

        // Random phases over several grid shapes; one runs with no gaps.
        random_phase(25);
        write_size(REG_GRID_WIDTH, 7);
        write_size(REG_GRID_HEIGHT, 5);
        quiesce();
        steady = 1'b1;
        random_phase(20);
        steady = 1'b0;
        write_size(REG_GRID_WIDTH, 1);
        write_size(REG_GRID_HEIGHT, DIM);
        quiesce();
        random_phase(15);
        write_size(REG_GRID_WIDTH, 13);
        write_size(REG_GRID_HEIGHT, 2);
        quiesce();
        random_phase(20);

        $display("Ran %0d transactions, %0d results over grids from 1 to %0d tiles wide.",
                 clicks_sent, answers_seen, DIM);
        $display("Status mix: open %0d, ring %0d, none %0d, outside %0d, toggled %0d, refused %0d",
                 status_seen[ST_START_OPEN], status_seen[ST_FOUND], status_seen[ST_NONE],
                 status_seen[ST_OUTSIDE], status_seen[ST_TOGGLED], status_seen[ST_REFUSED]);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/nfts_pkg.sv
rtl/nfts_ctrl.sv
rtl/nfts_datapath.sv
rtl/nearest_free_tile_spiral_search.sv
dv/nearest_free_tile_spiral_search_tb.sv
